// ===== sv/assert_macros.svh =====
// Assertion macros used by goal_line_of_sight_check, the RTL of the line-of-sight checker.
// Active in simulation; with SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, c, r, a, b)
`define ASSERT_NXT(lbl, c, r, a, b)
`endif
`endif

// ===== sv/glsc_pkg.sv =====
// Shared constants and types of the goal line-of-sight checker.
// No dependencies; used by glsc_mac and goal_line_of_sight_check.
package glsc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int THR_BITS = 16;
  localparam int LHS_SHIFT = 30;
  localparam logic signed [THR_BITS-1:0] COS_THR_RESET = 16'sd32440;

  typedef struct packed {
    logic load;
    logic clr;
    logic sub;
  } mac_ctrl_t;

endpackage

// ===== sv/goal_line_of_sight_check.sv =====
// An item that needs no arithmetic (scan stopped, goal at origin, no obstacle) goes from
// IDLE through CHECK straight to FIN; a full cone test runs through LOAD and RUN for each
// product, its length set by the bit-serial multiply-accumulate unit,
// which runs one pass per product and ends a pass early once its multiplier is spent.
// Throughput: one request at a time; the next is taken once the FSM is back in IDLE.
// Reset: synchronous, clears the running answer and the sequencer, reloads the threshold.
`include "assert_macros.svh"
module goal_line_of_sight_check #(
  parameter int COORD_BITS = glsc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [31:0] obs_x,
  input  logic signed [31:0] obs_y,
  input  logic               has_obstacle,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               goal_visible
);
  import glsc_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int BW  = 2 * CW + 1;
  localparam int DW  = 4 * CW + 1;
  localparam int PW  = 4 * CW + 34;
  localparam int PAD = PW - DW - LHS_SHIFT;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_LOAD    = 3'd2;
  localparam logic [2:0] ST_RUN     = 3'd3;
  localparam logic [2:0] ST_DECIDE  = 3'd4;
  localparam logic [2:0] ST_CMP     = 3'd5;
  localparam logic [2:0] ST_RESOLVE = 3'd6;
  localparam logic [2:0] ST_FIN     = 3'd7;

  localparam logic [3:0] OP_GX = 4'd0;
  localparam logic [3:0] OP_GY = 4'd1;
  localparam logic [3:0] OP_RX = 4'd2;
  localparam logic [3:0] OP_RY = 4'd3;
  localparam logic [3:0] OP_PX = 4'd4;
  localparam logic [3:0] OP_PY = 4'd5;
  localparam logic [3:0] OP_DD = 4'd6;
  localparam logic [3:0] OP_RG = 4'd7;
  localparam logic [3:0] OP_T1 = 4'd8;
  localparam logic [3:0] OP_T2 = 4'd9;

  logic [2:0] state;
  logic [3:0] op;

  logic signed [THR_BITS-1:0] cos_threshold;
  logic visible_so_far;
  logic scan_stopped;
  logic incone;

  logic [CW-1:0] gx, gy, rx, ry;
  logic          has_r, last_r;
  logic [BW-1:0] g2, r2, dmag;
  logic          dneg;
  logic [DW-1:0] dsq;

  logic [63:0] gx_ext, gy_ext, rx_ext, ry_ext;
  logic [CW-1:0] gx_mag, gy_mag, rx_mag, ry_mag;
  logic [THR_BITS-1:0] t_mag;
  logic          t_neg;

  mac_ctrl_t     mac_ctrl;
  logic [PW-1:0] mac_a, mac_acc, acc_neg, lhs;
  logic [BW-1:0] mac_b;
  logic          mac_done;
  logic          slot_free;

  assign gx_ext = {32'd0, goal_x};
  assign gy_ext = {32'd0, goal_y};
  assign rx_ext = {32'd0, obs_x};
  assign ry_ext = {32'd0, obs_y};

  assign gx_mag = gx[CW-1] ? (~gx + 1'b1) : gx;
  assign gy_mag = gy[CW-1] ? (~gy + 1'b1) : gy;
  assign rx_mag = rx[CW-1] ? (~rx + 1'b1) : rx;
  assign ry_mag = ry[CW-1] ? (~ry + 1'b1) : ry;

  assign t_neg = cos_threshold[THR_BITS-1];
  assign t_mag = t_neg ? (~cos_threshold + 1'b1) : cos_threshold;

  assign acc_neg   = '0 - mac_acc;
  assign lhs       = {{PAD{1'b0}}, dsq, {LHS_SHIFT{1'b0}}};
  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    mac_ctrl.load = (state == ST_LOAD);
    mac_ctrl.clr  = 1'b1;
    mac_ctrl.sub  = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    case (op) inside
      OP_GX: begin
        mac_a = PW'(gx_mag);
        mac_b = BW'(gx_mag);
      end
      OP_GY: begin
        mac_a        = PW'(gy_mag);
        mac_b        = BW'(gy_mag);
        mac_ctrl.clr = 1'b0;
      end
      OP_RX: begin
        mac_a = PW'(rx_mag);
        mac_b = BW'(rx_mag);
      end
      OP_RY: begin
        mac_a        = PW'(ry_mag);
        mac_b        = BW'(ry_mag);
        mac_ctrl.clr = 1'b0;
      end
      OP_PX: begin
        mac_a        = PW'(gx_mag);
        mac_b        = BW'(rx_mag);
        mac_ctrl.sub = gx[CW-1] ^ rx[CW-1];
      end
      OP_PY: begin
        mac_a        = PW'(gy_mag);
        mac_b        = BW'(ry_mag);
        mac_ctrl.clr = 1'b0;
        mac_ctrl.sub = gy[CW-1] ^ ry[CW-1];
      end
      OP_DD: begin
        mac_a = PW'(dmag);
        mac_b = dmag;
      end
      OP_RG: begin
        mac_a = PW'(r2);
        mac_b = g2;
      end
      OP_T1, OP_T2: begin
        mac_a = mac_acc;
        mac_b = BW'(t_mag);
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  glsc_mac #(
    .PW(PW),
    .BW(BW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .a_in (mac_a),
    .b_in (mac_b),
    .acc  (mac_acc),
    .done (mac_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_threshold <= COS_THR_RESET;
    end else if (cfg_we) begin
      cos_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      gx     <= gx_ext[CW-1:0];
      gy     <= gy_ext[CW-1:0];
      rx     <= rx_ext[CW-1:0];
      ry     <= ry_ext[CW-1:0];
      has_r  <= has_obstacle;
      last_r <= last_item;
    end
    if (state == ST_RUN && mac_done) begin
      case (op)
        OP_GY: g2 <= mac_acc[BW-1:0];
        OP_RY: r2 <= mac_acc[BW-1:0];
        OP_PY: begin
          dneg <= mac_acc[PW-1];
          dmag <= mac_acc[PW-1] ? acc_neg[BW-1:0] : mac_acc[BW-1:0];
        end
        OP_DD: dsq <= mac_acc[DW-1:0];
        default: begin
          dsq <= dsq;
        end
      endcase
    end
    if (state == ST_DECIDE) begin
      if (r2 == '0 || dmag == '0) begin
        incone <= t_neg;
      end else begin
        incone <= !dneg;
      end
    end else if (state == ST_CMP) begin
      incone <= dneg ? (lhs < mac_acc) : (lhs > mac_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      op             <= OP_GX;
      visible_so_far <= 1'b0;
      scan_stopped   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (scan_stopped) begin
            state <= ST_FIN;
          end else if (gx == '0 && gy == '0) begin
            visible_so_far <= 1'b1;
            scan_stopped   <= 1'b1;
            state          <= ST_FIN;
          end else if (!has_r) begin
            state <= ST_FIN;
          end else begin
            op    <= OP_GX;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (mac_done) begin
            case (op)
              OP_GX: begin
                op    <= OP_GY;
                state <= ST_LOAD;
              end
              OP_GY: begin
                op    <= OP_RX;
                state <= ST_LOAD;
              end
              OP_RX: begin
                op    <= OP_RY;
                state <= ST_LOAD;
              end
              OP_RY: begin
                op    <= OP_PX;
                state <= ST_LOAD;
              end
              OP_PX: begin
                op    <= OP_PY;
                state <= ST_LOAD;
              end
              OP_PY: state <= ST_DECIDE;
              OP_DD: begin
                op    <= OP_RG;
                state <= ST_LOAD;
              end
              OP_RG: begin
                op    <= OP_T1;
                state <= ST_LOAD;
              end
              OP_T1: begin
                op    <= OP_T2;
                state <= ST_LOAD;
              end
              OP_T2: state <= ST_CMP;
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_DECIDE: begin
          if (r2 == '0 || dmag == '0 || (dneg != t_neg)) begin
            state <= ST_RESOLVE;
          end else begin
            op    <= OP_DD;
            state <= ST_LOAD;
          end
        end
        ST_CMP: begin
          state <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          if (incone) begin
            if (r2 > g2) begin
              visible_so_far <= 1'b1;
            end else begin
              visible_so_far <= 1'b0;
              scan_stopped   <= 1'b1;
            end
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!last_r) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            visible_so_far <= 1'b0;
            scan_stopped   <= 1'b0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && last_r && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && last_r && slot_free) begin
      goal_visible <= visible_so_far;
    end
  end

  `ASSERT_NXT(a_accept_check, clk, rst, in_valid && !in_stall, state == ST_CHECK)
  `ASSERT_NXT(a_stop_skip, clk, rst, state == ST_CHECK && scan_stopped, state == ST_FIN)
  `ASSERT_IMP(a_result_src, clk, rst, $rose(out_valid), $past(state) == ST_FIN && last_r)

endmodule

// ===== sv/glsc_mac.sv =====
// Shift-and-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on glsc_pkg for the control struct.
module glsc_mac #(
  parameter int PW = 4 * glsc_pkg::COORD_BITS_DEF + 34,
  parameter int BW = 2 * glsc_pkg::COORD_BITS_DEF + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  glsc_pkg::mac_ctrl_t ctrl,
  input  logic [PW-1:0]      a_in,
  input  logic [BW-1:0]      b_in,
  output logic [PW-1:0]      acc,
  output logic               done
);
  import glsc_pkg::*;

  logic [PW-1:0] a;
  logic [BW-1:0] b;
  logic          sub;
  logic [PW-1:0] addend;
  logic [PW-1:0] sum;

  assign addend = b[0] ? a : '0;
  assign sum    = sub ? (acc - addend) : (acc + addend);
  assign done   = (b == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
    end else if (ctrl.load) begin
      b <= b_in;
    end else if (!done) begin
      b <= b >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a   <= a_in;
      sub <= ctrl.sub;
      if (ctrl.clr) begin
        acc <= '0;
      end
    end else if (!done) begin
      acc <= sum;
      a   <= a << 1;
    end
  end

endmodule
